>>> rtl/srbcr_pkg.sv
package srbcr_pkg;

   // field widths fixed by the interface
   localparam int IDX_W     = 13;
   localparam int COORD_W   = 14;
   localparam int CFG_W     = 11;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   // coordinate format
   localparam int FRAC_BITS = 4;
   localparam int HALF_UNIT = (1 << FRAC_BITS) >> 1;

   // default sizing
   localparam int MAX_ROWS_DEF      = 1024;
   localparam int MAX_KEYPOINTS_DEF = 4096;

   // register reset values
   localparam logic [CFG_W-1:0] IMAGE_ROWS_RST      = CFG_W'(480);
   localparam logic [CFG_W-1:0] VERTICAL_OFFSET_RST = CFG_W'(2);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_VERTICAL_OFFSET = CSR_IDX_W'(1);

   // operations
   localparam logic [OP_W-1:0] OP_CLEAR = OP_W'(0);
   localparam logic [OP_W-1:0] OP_ADD   = OP_W'(1);
   localparam logic [OP_W-1:0] OP_QUERY = OP_W'(2);

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK          = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_OUT_OF_ORDER = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_OUTSIDE     = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = STATUS_W'(3);

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [COORD_W-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]    range_start;
      logic [IDX_W-1:0]    range_end;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

>>> rtl/stereo_row_band_candidate_range.sv
// Row-band candidate lookup for stereo keypoint matching. Right-image keypoint
// rows are added in ascending order (operation add); the block keeps a table
// that maps each image row to the index of the first right keypoint at or
// below that row. A query with a left keypoint row returns the half-open index
// range [range_start, range_end) of right keypoints whose rows lie within
// vertical_offset of the rounded query row. Clear restarts the table. A word
// is taken when start is high and busy is low; exactly one result word comes
// back per request, on rsp_word for the single cycle that rsp_strobe is high.
// The receiver cannot stall, so it must take every strobed word. Clear, unused
// codes, rejected adds and adds that open no new row answer from the decode
// state; an add that opens rows passes the fill state, whose single table write
// port fills one row per cycle up to the new row; a query makes two registered
// reads through the one table read port, in the read-low, read-high and
// query-end states. busy stays high until the result is issued. Registers are
// written through the csr_ port only while the block is idle: a rule for the
// user; the block does not enforce it. No clearing pass is needed after reset.
module stereo_row_band_candidate_range #(
   parameter int MAX_ROWS      = srbcr_pkg::MAX_ROWS_DEF,
   parameter int MAX_KEYPOINTS = srbcr_pkg::MAX_KEYPOINTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  srbcr_pkg::req_type                  req_word,
   // result channel
   output logic                                rsp_strobe,
   output srbcr_pkg::rsp_type                  rsp_word,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [srbcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [srbcr_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int ADDR_W  = $clog2(MAX_ROWS + 1);
   // row values: up to max(image_rows, MAX_ROWS) and table addresses
   localparam int ROW_W   = (ADDR_W > srbcr_pkg::CFG_W + 1) ? ADDR_W : srbcr_pkg::CFG_W + 1;
   localparam int CNT_W   = $clog2(MAX_KEYPOINTS + 1);
   // query band ends before clipping
   localparam int Q_W     = srbcr_pkg::COORD_W + 1;
   localparam int CMP_W   = ((Q_W > ROW_W) ? Q_W : ROW_W) + 1;
   localparam int DEPTH   = MAX_ROWS + 1;

   localparam logic [ROW_W-1:0] MAX_ROWS_V = ROW_W'(MAX_ROWS);
   localparam logic [CNT_W-1:0] MAX_KP_V   = CNT_W'(MAX_KEYPOINTS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FILL,
      S_READ_LO,
      S_READ_HI,
      S_QUERY_END
   } state_type;

   state_type                        state_ff;

   // configuration
   logic [srbcr_pkg::CFG_W-1:0]      image_rows_ff;
   logic [srbcr_pkg::CFG_W-1:0]      vertical_offset_ff;

   // latched request
   logic [srbcr_pkg::OP_W-1:0]       op_ff;
   logic [srbcr_pkg::COORD_W-1:0]    coord_ff;

   // table bookkeeping
   logic [ROW_W-1:0]                 filled_rows_ff;
   logic [CNT_W-1:0]                 right_count_ff;
   logic [ROW_W-1:0]                 fill_ptr_ff;
   logic [ROW_W-1:0]                 fill_row_ff;

   // query band
   logic [Q_W-1:0]                   lo_ff;
   logic [Q_W-1:0]                   hi_ff;
   logic                             lo_hit_ff;
   logic [CNT_W-1:0]                 start_idx_ff;

   // result register
   logic                             rsp_strobe_ff;
   srbcr_pkg::rsp_type               rsp_word_ff;

   // row table: one write port, one registered read port
   logic [CNT_W-1:0]                 tbl_mem [DEPTH];
   logic [CNT_W-1:0]                 tbl_rdata_ff;
   logic                             tbl_wr_en;
   logic [ADDR_W-1:0]                tbl_waddr;
   logic [ADDR_W-1:0]                tbl_raddr;

   // decode terms
   logic [ROW_W-1:0]                 rows_eff;
   logic [srbcr_pkg::COORD_W-1:0]    add_row;
   logic                             add_outside;
   logic                             add_order;
   logic                             add_full;
   logic                             add_opens;
   logic [Q_W-1:0]                   q_row;
   logic [Q_W-1:0]                   q_limit;
   logic [Q_W-1:0]                   q_lo;
   logic [Q_W-1:0]                   q_hi;
   logic                             hi_hit;

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // image_rows above MAX_ROWS acts as MAX_ROWS
   always_comb begin
      rows_eff = (ROW_W'(image_rows_ff) > MAX_ROWS_V) ? MAX_ROWS_V : ROW_W'(image_rows_ff);
   end

   always_comb begin
      add_row     = coord_ff >> srbcr_pkg::FRAC_BITS;
      add_outside = (CMP_W'(add_row) >= CMP_W'(rows_eff));
      add_order   = ((CMP_W'(add_row) + CMP_W'(1)) < CMP_W'(filled_rows_ff));
      add_full    = (right_count_ff >= MAX_KP_V);
      add_opens   = (CMP_W'(add_row) >= CMP_W'(filled_rows_ff));

      // round to nearest row, then widen by the offset on both sides
      q_row = Q_W'((Q_W'(coord_ff) + Q_W'(srbcr_pkg::HALF_UNIT)) >> srbcr_pkg::FRAC_BITS);
      q_lo  = (q_row >= Q_W'(vertical_offset_ff)) ? (q_row - Q_W'(vertical_offset_ff))
                                                   : Q_W'(0);
      q_hi  = q_row + Q_W'(vertical_offset_ff) + Q_W'(1);

      // both band ends clip to rows+1; the filled part may reach past that
      // when image_rows shrinks under a kept table
      q_limit = Q_W'(rows_eff) + Q_W'(1);
      if (q_lo > q_limit) begin
         q_lo = q_limit;
      end
      if (q_hi > q_limit) begin
         q_hi = q_limit;
      end

      // band ends at or past the filled part read as right_count
      hi_hit = (CMP_W'(hi_ff) < CMP_W'(filled_rows_ff));
   end

   always_comb begin
      tbl_wr_en = (state_ff == S_FILL);
      tbl_waddr = ADDR_W'(fill_ptr_ff);
      tbl_raddr = (state_ff == S_READ_HI) ? ADDR_W'(hi_ff) : ADDR_W'(lo_ff);
   end

   always_ff @(posedge clock) begin
      if (tbl_wr_en) begin
         tbl_mem[tbl_waddr] <= right_count_ff;
      end
      tbl_rdata_ff <= tbl_mem[tbl_raddr];
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_rows_ff      <= srbcr_pkg::IMAGE_ROWS_RST;
         vertical_offset_ff <= srbcr_pkg::VERTICAL_OFFSET_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            srbcr_pkg::CSR_IMAGE_ROWS:      image_rows_ff      <= csr_wdata;
            srbcr_pkg::CSR_VERTICAL_OFFSET: vertical_offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         filled_rows_ff <= '0;
         right_count_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff    <= req_word.operation;
                  coord_ff <= req_word.coord_y;
                  state_ff <= S_DECODE;
               end
            end

            S_DECODE: begin
               unique case (op_ff)
                  srbcr_pkg::OP_CLEAR: begin
                     filled_rows_ff          <= '0;
                     right_count_ff          <= '0;
                     rsp_strobe_ff           <= 1'b1;
                     rsp_word_ff.range_start <= '0;
                     rsp_word_ff.range_end   <= '0;
                     rsp_word_ff.status      <= srbcr_pkg::ST_OK;
                     state_ff                <= S_IDLE;
                  end
                  srbcr_pkg::OP_ADD: begin
                     priority if (add_outside || add_order || add_full) begin
                        // rejected: first fault wins, table untouched
                        rsp_strobe_ff           <= 1'b1;
                        rsp_word_ff.range_start <= srbcr_pkg::IDX_W'(right_count_ff);
                        rsp_word_ff.range_end   <= srbcr_pkg::IDX_W'(right_count_ff);
                        if (add_outside) begin
                           rsp_word_ff.status <= srbcr_pkg::ST_OUTSIDE;
                        end else if (add_order) begin
                           rsp_word_ff.status <= srbcr_pkg::ST_OUT_OF_ORDER;
                        end else begin
                           rsp_word_ff.status <= srbcr_pkg::ST_TABLE_FULL;
                        end
                        state_ff <= S_IDLE;
                     end else if (add_opens) begin
                        fill_ptr_ff <= filled_rows_ff;
                        fill_row_ff <= ROW_W'(add_row);
                        state_ff    <= S_FILL;
                     end else begin
                        // same row as the last keypoint: only the count moves
                        right_count_ff          <= right_count_ff + CNT_W'(1);
                        rsp_strobe_ff           <= 1'b1;
                        rsp_word_ff.range_start <= srbcr_pkg::IDX_W'(right_count_ff);
                        rsp_word_ff.range_end   <=
                           srbcr_pkg::IDX_W'(right_count_ff + CNT_W'(1));
                        rsp_word_ff.status      <= srbcr_pkg::ST_OK;
                        state_ff                <= S_IDLE;
                     end
                  end
                  srbcr_pkg::OP_QUERY: begin
                     lo_ff    <= q_lo;
                     hi_ff    <= q_hi;
                     state_ff <= S_READ_LO;
                  end
                  default: begin
                     rsp_strobe_ff           <= 1'b1;
                     rsp_word_ff.range_start <= '0;
                     rsp_word_ff.range_end   <= '0;
                     rsp_word_ff.status      <= srbcr_pkg::ST_OK;
                     state_ff                <= S_IDLE;
                  end
               endcase
            end

            S_FILL: begin
               // one new row per cycle gets the current count
               if (fill_ptr_ff == fill_row_ff) begin
                  filled_rows_ff          <= fill_row_ff + ROW_W'(1);
                  right_count_ff          <= right_count_ff + CNT_W'(1);
                  rsp_strobe_ff           <= 1'b1;
                  rsp_word_ff.range_start <= srbcr_pkg::IDX_W'(right_count_ff);
                  rsp_word_ff.range_end   <= srbcr_pkg::IDX_W'(right_count_ff + CNT_W'(1));
                  rsp_word_ff.status      <= srbcr_pkg::ST_OK;
                  state_ff                <= S_IDLE;
               end else begin
                  fill_ptr_ff <= fill_ptr_ff + ROW_W'(1);
               end
            end

            S_READ_LO: begin
               // read of the low end issued this cycle
               lo_hit_ff <= (CMP_W'(lo_ff) < CMP_W'(filled_rows_ff));
               state_ff  <= S_READ_HI;
            end

            S_READ_HI: begin
               start_idx_ff <= lo_hit_ff ? tbl_rdata_ff : right_count_ff;
               state_ff     <= S_QUERY_END;
            end

            S_QUERY_END: begin
               rsp_strobe_ff           <= 1'b1;
               rsp_word_ff.range_start <= srbcr_pkg::IDX_W'(start_idx_ff);
               rsp_word_ff.range_end   <=
                  srbcr_pkg::IDX_W'(hi_hit ? tbl_rdata_ff : right_count_ff);
               rsp_word_ff.status      <= srbcr_pkg::ST_OK;
               state_ff                <= S_IDLE;
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   a_one_word_per_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on two cycles in a row");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (right_count_ff <= MAX_KP_V) && (filled_rows_ff <= MAX_ROWS_V))
      else $error("keypoint count or filled rows beyond table size");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (fill_ptr_ff <= fill_row_ff))
      else $error("row fill pointer ran past its target row");
`endif

endmodule

>>> dv/tb.sv
// Testbench for the stereo row-band candidate range block.
// Words go in on the start/busy command port and each one brings back exactly
// one rsp word, strobed for a single cycle. A predictor inside the bench keeps
// its own copy of the row table, the keypoint count and both registers. It
// works out the expected rsp word at the edge where the request word is taken.
// A checker pops that expectation when the strobe comes.
module tb;

   localparam int CLK_PERIOD     = 12;
   localparam int MAX_ROWS       = srbcr_pkg::MAX_ROWS_DEF;
   localparam int MAX_KEYPOINTS  = srbcr_pkg::MAX_KEYPOINTS_DEF;
   localparam int COORD_W        = srbcr_pkg::COORD_W;
   localparam int CFG_W          = srbcr_pkg::CFG_W;
   localparam int IDX_W          = srbcr_pkg::IDX_W;
   localparam int OP_W           = srbcr_pkg::OP_W;
   localparam int FRAC_BITS      = srbcr_pkg::FRAC_BITS;
   localparam int HALF_UNIT      = srbcr_pkg::HALF_UNIT;
   localparam int COORD_MAX      = (1 << COORD_W) - 1;
   localparam int TIMEOUT_CYCLES = 2_000_000;

   // The encoding leaves code 3 unused; the block must answer it with zeros.
   localparam logic [OP_W-1:0] OP_UNUSED = OP_W'(3);

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   srbcr_pkg::req_type                req_word = '0;
   logic                              rsp_strobe;
   srbcr_pkg::rsp_type                rsp_word;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [srbcr_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [CFG_W-1:0]                  csr_wdata = '0;

   stereo_row_band_candidate_range dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predictor state: the row table, how many leading rows hold a value,
   // the number of accepted right keypoints, and the two registers.
   // ---------------------------------------------------------------------
   logic [IDX_W-1:0] band_table [0:MAX_ROWS];
   int               tbl_filled = 0;
   int               kp_count   = 0;
   logic [CFG_W-1:0] cfg_rows   = srbcr_pkg::IMAGE_ROWS_RST;
   logic [CFG_W-1:0] cfg_offset = srbcr_pkg::VERTICAL_OFFSET_RST;

   srbcr_pkg::rsp_type pending_ranges [$];   // expected rsp words, oldest first
   int                 error_count = 0;

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Rows at or past the filled mark read back as the running keypoint count.
   // That is the value they would get once written, so stale entries never leak.
   function automatic int row_lookup(input int k);
      if (k < tbl_filled && k <= MAX_ROWS)
         return int'(band_table[k]);
      return kp_count;
   endfunction

   // Applies one request word to the predictor state and returns its rsp word.
   function automatic srbcr_pkg::rsp_type predict_band(input srbcr_pkg::req_type w);
      srbcr_pkg::rsp_type r;
      int                 rows, row, v, lo, hi, limit, k;
      r = '0;
      r.status = srbcr_pkg::ST_OK;
      // image_rows above the table size acts as the table size
      rows = (int'(cfg_rows) > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
      case (w.operation)
         srbcr_pkg::OP_CLEAR: begin
            tbl_filled = 0;
            kp_count   = 0;
         end
         srbcr_pkg::OP_ADD: begin
            row = int'(w.coord_y) >> FRAC_BITS;   // floor to a pixel row
            r.range_start = IDX_W'(kp_count);
            r.range_end   = IDX_W'(kp_count);
            // fault priority: outside image, then out of order, then full
            if (row >= rows)
               r.status = srbcr_pkg::ST_OUTSIDE;
            else if (tbl_filled > 0 && row + 1 < tbl_filled)
               r.status = srbcr_pkg::ST_OUT_OF_ORDER;
            else if (kp_count >= MAX_KEYPOINTS)
               r.status = srbcr_pkg::ST_TABLE_FULL;
            else begin
               for (k = tbl_filled; k <= row; k++)
                  band_table[k] = IDX_W'(kp_count);
               if (row + 1 > tbl_filled)
                  tbl_filled = row + 1;
               kp_count++;
               r.range_end = IDX_W'(kp_count);
            end
         end
         srbcr_pkg::OP_QUERY: begin
            // round to the nearest row, then open the band around it
            v     = (int'(w.coord_y) + HALF_UNIT) >> FRAC_BITS;
            limit = rows + 1;
            lo    = (v >= int'(cfg_offset)) ? v - int'(cfg_offset) : 0;
            hi    = v + int'(cfg_offset) + 1;
            if (lo > limit) lo = limit;
            if (hi > limit) hi = limit;
            r.range_start = IDX_W'(row_lookup(lo));
            r.range_end   = IDX_W'(row_lookup(hi));
         end
         default: ;   // unused code: no state change, zero fields
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Checker: the receiver cannot stall, so every strobed word is taken at
   // the edge that closes its cycle and matched against the oldest guess.
   // ---------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [IDX_W-1:0] want,
                                       input logic [IDX_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_ranges
      srbcr_pkg::rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_ranges.size() == 0) begin
            error_count++;
            $display("%0t: rsp word with none expected, expected nothing, actual %h",
                     $time, rsp_word);
         end else begin
            want = pending_ranges.pop_front();
            check_field("range_start", want.range_start, rsp_word.range_start);
            check_field("range_end", want.range_end, rsp_word.range_end);
            check_field("status", IDX_W'(want.status), IDX_W'(rsp_word.status));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver helpers
   // ---------------------------------------------------------------------

   // Sends one request word. With idle_pct, start first drops for a random gap
   // that can outlast a query, so gaps land on every phase of the block's work.
   // start is left high on return, and the next call either swaps the word in
   // the same step or lowers start.
   task automatic send_word(input logic [OP_W-1:0] op, input int coord, input int idle_pct);
      srbcr_pkg::req_type w;
      int                 gap;
      if (coord < 0) coord = 0;
      if (coord > COORD_MAX) coord = COORD_MAX;
      w.operation = op;
      w.coord_y   = COORD_W'(coord);
      gap = 0;
      if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
         gap = $urandom_range(6, 1);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word <= w;
      start    <= 1'b1;
      // taken at the first edge where busy was low
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_ranges.insert(pending_ranges.size(), predict_band(w));
   endtask

   // Drops start and lets every outstanding rsp word arrive. Every request
   // brings back a word, so an empty queue means the block is idle. A few
   // extra cycles follow for margin.
   task automatic wait_idle;
      start <= 1'b0;
      while (pending_ranges.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes both registers back to back; valid stays high across the pair.
   task automatic config_band(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] offset);
      csr_valid <= 1'b1;
      csr_index <= srbcr_pkg::CSR_IMAGE_ROWS;
      csr_wdata <= rows;
      do @(posedge clock); while (!csr_ready);
      cfg_rows = rows;
      csr_index <= srbcr_pkg::CSR_VERTICAL_OFFSET;
      csr_wdata <= offset;
      do @(posedge clock); while (!csr_ready);
      cfg_offset = offset;
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed keypoint streams: a clear now and then, ascending
   // adds with a random fraction, and queries around the image. The rest is
   // noise: adds below the last row, adds outside the image, any code.
   task automatic run_traffic(input int idle_pct, input int count);
      int              cursor, rows_eff, pick, row, coord;
      logic [OP_W-1:0] op;
      cursor   = 0;
      rows_eff = (int'(cfg_rows) > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
      repeat (count) begin
         pick = $urandom_range(99, 0);
         op   = srbcr_pkg::OP_ADD;
         if (pick < 4) begin
            op     = srbcr_pkg::OP_CLEAR;
            coord  = $urandom_range(COORD_MAX, 0);
            cursor = 0;
         end else if (pick < 50) begin
            // in-order add; big jumps sometimes open many rows at once
            pick = $urandom_range(99, 0);
            if (pick < 70)
               cursor += $urandom_range(1, 0);
            else if (pick < 95)
               cursor += $urandom_range(8, 2);
            else
               cursor += $urandom_range(rows_eff / 4 + 1, 0);
            coord = cursor * (1 << FRAC_BITS) + int'($urandom_range(15, 0));
         end else if (pick < 88) begin
            op    = srbcr_pkg::OP_QUERY;
            row   = $urandom_range(rows_eff + 2, 0);
            coord = row * (1 << FRAC_BITS) + int'($urandom_range(15, 0)) - HALF_UNIT;
         end else if (pick < 93) begin
            // below the last row: out of order unless the table was cleared
            row   = (cursor > 0) ? int'($urandom_range(cursor - 1, 0)) : 0;
            coord = row * (1 << FRAC_BITS) + int'($urandom_range(15, 0));
         end else if (pick < 97) begin
            op    = OP_W'($urandom_range(3, 0));
            coord = $urandom_range(COORD_MAX, 0);
         end else begin
            row   = $urandom_range(1023, (rows_eff < 1023) ? rows_eff : 1023);
            coord = row * (1 << FRAC_BITS) + int'($urandom_range(15, 0));
         end
         send_word(op, coord, idle_pct);
      end
   endtask

   task automatic run_setting(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] offset,
                              input int idle_pct, input int count);
      wait_idle();
      config_band(rows, offset);
      run_traffic(idle_pct, count);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset settings (480 rows, offset 2): empty table, rounding at the half
   // row, ordering faults, the image edge, the unused code and clear.
   task automatic test_directed;
      send_word(srbcr_pkg::OP_QUERY, 0, 0);                  // empty table
      send_word(srbcr_pkg::OP_QUERY, COORD_MAX, 0);
      send_word(srbcr_pkg::OP_ADD, 0, 0);                    // row 0
      send_word(srbcr_pkg::OP_ADD, 15, 0);                   // row 0 again, fraction all ones
      send_word(srbcr_pkg::OP_ADD, 5 * 16 + 3, 0);           // opens rows 1..5
      send_word(srbcr_pkg::OP_ADD, 3 * 16, 0);               // below last row: out of order
      send_word(srbcr_pkg::OP_ADD, 5 * 16 + 15, 0);          // same row as last: accepted
      send_word(srbcr_pkg::OP_ADD, 479 * 16 + 15, 0);        // last row of the image
      send_word(srbcr_pkg::OP_ADD, 480 * 16, 0);             // first row outside
      send_word(srbcr_pkg::OP_ADD, COORD_MAX, 0);
      send_word(srbcr_pkg::OP_QUERY, 5 * 16 + 7, 0);         // rounds down
      send_word(srbcr_pkg::OP_QUERY, 5 * 16 + 8, 0);         // rounds up
      send_word(srbcr_pkg::OP_QUERY, 0, 0);                  // low band end clipped at 0
      send_word(srbcr_pkg::OP_QUERY, COORD_MAX, 0);          // far below the image
      send_word(srbcr_pkg::OP_QUERY, 479 * 16, 0);
      send_word(OP_UNUSED, COORD_MAX, 0);
      send_word(OP_UNUSED, 0, 0);
      send_word(srbcr_pkg::OP_CLEAR, COORD_MAX, 0);
      send_word(srbcr_pkg::OP_QUERY, 5 * 16, 0);             // after clear
      send_word(srbcr_pkg::OP_ADD, 4 * 16, 0);               // lower row fine after clear
      send_word(srbcr_pkg::OP_QUERY, 4 * 16, 0);
      send_word(srbcr_pkg::OP_CLEAR, 0, 0);
   endtask

   // Register extremes. The table is not cleared between settings, so a
   // change of rows on a filled table is exercised as well.
   task automatic test_register_extremes;
      run_setting(CFG_W'(0), CFG_W'(2), 0, 40);        // every add outside
      run_setting(CFG_W'(1), CFG_W'(0), 0, 40);
      run_setting(CFG_W'(1), CFG_W'(2047), 0, 40);
      run_setting(CFG_W'(1024), CFG_W'(1024), 0, 40);
      run_setting(CFG_W'(2047), CFG_W'(0), 0, 40);     // acts as the table size
      run_setting(CFG_W'(13), CFG_W'(2047), 0, 40);
      run_setting(CFG_W'(1024), CFG_W'(1), 0, 40);
   endtask

   // Dense table: four keypoints on every fourth row, then one add that
   // fills up to the last table row, and the image shrunk under the table.
   task automatic test_dense_table;
      int i;
      wait_idle();
      config_band(CFG_W'(MAX_ROWS), CFG_W'(2047));
      send_word(srbcr_pkg::OP_CLEAR, 0, 0);
      for (i = 0; i < 256; i++)
         send_word(srbcr_pkg::OP_ADD, (i / 4) * 64 + (i % 4) * 4, 0);
      send_word(srbcr_pkg::OP_ADD, 1023 * 16 + 15, 0);      // long fill to the last row
      send_word(srbcr_pkg::OP_ADD, 100 * 16, 0);            // out of order
      send_word(srbcr_pkg::OP_QUERY, 512 * 16, 0);          // whole range
      send_word(srbcr_pkg::OP_QUERY, COORD_MAX, 0);
      // shrink the image under the filled table
      wait_idle();
      config_band(CFG_W'(1000), CFG_W'(3));
      send_word(srbcr_pkg::OP_ADD, 1010 * 16, 0);           // outside wins over order
      send_word(srbcr_pkg::OP_QUERY, 999 * 16, 0);          // high end clipped mid-table
      send_word(srbcr_pkg::OP_QUERY, COORD_MAX, 0);
      send_word(srbcr_pkg::OP_QUERY, 0, 0);
      send_word(srbcr_pkg::OP_CLEAR, 0, 0);
      send_word(srbcr_pkg::OP_QUERY, 500 * 16, 0);
   endtask

   // Random settings at each idling level: none, heavy, light.
   task automatic test_random_traffic;
      int               idle_levels [3];
      int               pick;
      logic [CFG_W-1:0] rows, offset;
      idle_levels = '{0, 58, 10};
      foreach (idle_levels[n]) begin
         repeat (2) begin
            pick = $urandom_range(9, 0);
            if (pick < 8)
               rows = CFG_W'($urandom_range(1024, 1));
            else if (pick < 9)
               rows = CFG_W'($urandom_range(40, 1));
            else
               rows = CFG_W'($urandom_range(2047, 1025));
            offset = ($urandom_range(9, 0) < 8) ? CFG_W'($urandom_range(8, 0))
                                                : CFG_W'($urandom_range(2047, 0));
            run_setting(rows, offset, idle_levels[n], 195);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_dense_table();
      test_random_traffic();
      // let the last words come home, then watch for strays
      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_ranges.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("FAILURE");
      $finish;
   end

endmodule
